// ----- rtl/core/ncs_pkg.sv -----
package ncs_pkg;

    localparam int DelayDepthDef = 512;
    localparam int SampleBitsDef = 24;
    localparam int CfgIdxBits    = 3;
    localparam int CfgDataBits   = 16;

    localparam logic [CfgIdxBits-1:0] REG_MODE     = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_TONE     = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_FEEDBACK = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_CUTOFF   = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_LEVEL    = 3'd4;

    localparam logic [1:0] MODE_WHITE = 2'd0;
    localparam logic [1:0] MODE_PINK  = 2'd1;
    localparam logic [1:0] MODE_METAL = 2'd2;

    localparam logic [15:0] LEVEL_MUTE = 16'd6;

    // Q0.24 coefficients
    localparam logic signed [25:0] K_PINK_OUT = 26'sd1845494;
    localparam logic signed [25:0] K_PINK_W6  = 26'sd8995943;
    localparam logic signed [25:0] K_PINK_T6  = 26'sd1944916;
    localparam logic signed [25:0] K_METAL_W  = 26'sd5033165;

    function automatic logic signed [25:0] pink_decay(input logic [2:0] k);
        case (k)
            3'd0:    pink_decay = 26'sd16758090;
            3'd1:    pink_decay = 26'sd16665144;
            3'd2:    pink_decay = 26'sd16257122;
            3'd3:    pink_decay = 26'sd14537458;
            3'd4:    pink_decay = 26'sd9227469;
            3'd5:    pink_decay = -26'sd12777528;
            default: pink_decay = 26'sd0;
        endcase
    endfunction

    function automatic logic signed [25:0] pink_gain(input logic [2:0] k);
        case (k)
            3'd0:    pink_gain = 26'sd931436;
            3'd1:    pink_gain = 26'sd1259565;
            3'd2:    pink_gain = 26'sd2581208;
            3'd3:    pink_gain = 26'sd5209084;
            3'd4:    pink_gain = 26'sd8941454;
            3'd5:    pink_gain = -26'sd283501;
            default: pink_gain = 26'sd0;
        endcase
    endfunction

    // Datapath opcodes, one per serial multiply-accumulate step
    typedef enum logic [3:0] {
        OP_NONE, OP_PINK_TAP, OP_PINK_SUM, OP_PINK_T6, OP_PINK_OUT,
        OP_MET_W, OP_MET_FB, OP_LP, OP_OUT
    } t_op;

endpackage

// ----- rtl/core/ncs_if.sv -----
interface ncs_in_if #(parameter int SAMPLE_BITS = ncs_pkg::SampleBitsDef);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] white_sample;
    logic                          block_end;
    modport source (output valid, white_sample, block_end, input ready);
    modport sink   (input valid, white_sample, block_end, output ready);
endinterface

interface ncs_out_if #(parameter int SAMPLE_BITS = ncs_pkg::SampleBitsDef);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] shaped_sample;
    logic                          block_end_out;
    modport source (output valid, shaped_sample, block_end_out, input ready);
    modport sink   (input valid, shaped_sample, block_end_out, output ready);
endinterface

interface ncs_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ncs_pkg::CfgIdxBits-1:0]       index;
    logic [ncs_pkg::CfgDataBits-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ncs_ram.sv -----
module ncs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/ncs_serial_mul.sv -----
// Bit-serial signed multiplier: A (AW bits) times B (26 bits), shift-add, one B bit a cycle.
module ncs_serial_mul #(
    parameter int AW = 34
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [AW-1:0]      i_a,
    input  logic signed [25:0]        i_b,
    output logic                      o_done,
    output logic signed [AW+25:0]     o_prod
);
    localparam int PW = AW + 26;

    logic signed [PW-1:0] r_acc, n_acc;
    logic signed [PW-1:0] r_a, n_a;
    logic [25:0]          r_b, n_b;
    logic [4:0]           r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = PW'(i_a);
            n_b    = i_b;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // top bit of B carries negative weight
            if (r_b[0]) begin
                n_acc = (r_cnt == 5'd25) ? r_acc - r_a : r_acc + r_a;
            end
            n_a   = r_a <<< 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd25) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("start while busy");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 5'd25 && !i_start) |=> r_done)
        else $error("missing done");
`endif
endmodule

// ----- rtl/core/noise_colour_shaper_unit.sv -----
// A muted item goes straight to the output register; otherwise each item runs serial multiplies:
//   white 2, metallic 4 (plus delay reads and write-back), pink 17.
// Throughput: one item at a time; the next item is taken once the result is registered
// and the output register is empty or being read, so a waiting result stalls the input.
// Reset (synchronous, i_rst_n low) clears registers, taps and lowpass memory,
// then sweeps the delay RAM to zero, one entry a cycle.
module noise_colour_shaper_unit #(
    parameter int DELAY_DEPTH = ncs_pkg::DelayDepthDef,
    parameter int SAMPLE_BITS = ncs_pkg::SampleBitsDef
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ncs_in_if.sink   i_in,
    ncs_out_if.source o_out,
    ncs_cfg_if.sink  i_cfg
);
    localparam int AW  = 34;
    localparam int PW  = AW + 26;
    localparam int DAW = $clog2(DELAY_DEPTH);
    localparam int SB  = SAMPLE_BITS;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_NEXT  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic [1:0]         r_mode;
    logic [15:0]        r_tone, r_cutoff, r_level;
    logic signed [15:0] r_fb;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ncs_pkg::MODE_WHITE;
            r_tone   <= '0;
            r_fb     <= '0;
            r_cutoff <= 16'hFFFF;
            r_level  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ncs_pkg::REG_MODE:     r_mode   <= i_cfg.data[1:0];
                ncs_pkg::REG_TONE:     r_tone   <= i_cfg.data;
                ncs_pkg::REG_FEEDBACK: r_fb     <= i_cfg.data;
                ncs_pkg::REG_CUTOFF:   r_cutoff <= i_cfg.data;
                ncs_pkg::REG_LEVEL:    r_level  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // datapath state
    logic signed [31:0]   r_tap [7];
    logic signed [31:0]   r_lp;
    logic [DAW-1:0]       r_widx;
    logic [DAW-1:0]       r_clr;
    logic signed [SB-1:0] r_w;
    logic                 r_be;
    logic signed [AW+2:0] r_acc;   // running sum of rounded products
    logic [2:0]           r_k;
    ncs_pkg::t_op         r_op;
    logic signed [SB-1:0] r_d1, r_d2;
    logic signed [31:0]   r_x;
    logic [1:0]           r_rdph;
    logic signed [PW-1:0] r_prod;  // decay product of the current pink tap

    logic                 r_ovalid;
    logic signed [SB-1:0] r_osample;
    logic                 r_obe;

    // multiplier operands
    logic                 r_mul_start;
    logic signed [AW-1:0] mul_a;
    logic signed [25:0]   mul_b;
    logic                 mul_done;
    logic signed [PW-1:0] mul_p;

    ncs_serial_mul #(.AW(AW)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (mul_p)
    );

    // delay line
    logic [15:0]          len_raw, len_mod;
    logic [DAW-1:0]       len_m, r1, r2, ram_raddr;
    logic [23:0]          tone_mul;
    logic                 r_ram_we;
    logic [DAW-1:0]       r_ram_waddr;
    logic [SB-1:0]        r_ram_wdata, ram_rdata;

    assign tone_mul = {r_tone, 8'd0} - {6'd0, r_tone, 2'd0} - {7'd0, r_tone, 1'b0};
    assign len_raw  = 16'(tone_mul[23:16]) + 16'd6;
    // length can exceed a short line by a few entries
    assign len_mod  = (len_raw >= 16'(DELAY_DEPTH)) ? len_raw - 16'(DELAY_DEPTH) : len_raw;
    assign len_m    = DAW'(len_mod);
    assign r1       = (r_widx >= len_m) ? r_widx - len_m
                                        : r_widx + DAW'(DELAY_DEPTH) - len_m;
    assign r2       = (r1 == '0) ? DAW'(DELAY_DEPTH - 1) : r1 - DAW'(1);
    assign ram_raddr = (r_rdph == 2'd0) ? r1 : r2;

    ncs_ram #(.WIDTH(SB), .DEPTH(DELAY_DEPTH)) u_delay (
        .i_clk  (i_clk),
        .i_we   (r_ram_we),
        .i_waddr(r_ram_waddr),
        .i_wdata(r_ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // rounding helpers
    function automatic logic signed [AW+2:0] rnd_p(input logic signed [PW-1:0] p,
                                                   input int s);
        logic signed [PW:0] t;
        t = (PW+1)'(p) + ((PW+1)'(1) <<< (s - 1));
        rnd_p = (AW+3)'(t >>> s);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [AW+2:0] v);
        if (v > (AW+3)'(64'sh7FFF_FFFF))       sat32 = 32'sh7FFF_FFFF;
        else if (v < -(AW+3)'(64'sh8000_0000)) sat32 = 32'sh8000_0000;
        else                                   sat32 = 32'(v);
    endfunction

    function automatic logic signed [SB-1:0] satsb(input logic signed [AW+2:0] v);
        logic signed [AW+2:0] hi;
        hi = ((AW+3)'(1) <<< (SB - 1)) - (AW+3)'(1);
        if (v > hi)             satsb = {1'b0, {(SB-1){1'b1}}};
        else if (v < -hi - 1)   satsb = {1'b1, {(SB-1){1'b0}}};
        else                    satsb = SB'(v);
    endfunction

    logic signed [AW+2:0] lp_ext, x_ext;
    logic signed [AW+2:0] v_met;
    logic [31:0]          cut_sq;
    logic signed [25:0]   coef_c;
    logic signed [31:0]   tap_new;
    logic signed [AW+2:0] tap6_add;

    assign lp_ext = (AW+3)'(r_lp);
    assign x_ext  = (AW+3)'(r_x);
    assign cut_sq = r_cutoff * r_cutoff;
    // c = rnd(fc^2, 8), at most 2^24
    assign coef_c = 26'((33'(cut_sq) + 33'd128) >> 8);
    assign v_met  = (r_acc + (AW+3)'(r_d2) + (AW+3)'(1)) >>> 1;
    assign tap_new  = sat32(rnd_p(r_prod + mul_p, 24));
    // old tap 6 joins the sum with the last tap
    assign tap6_add = (r_k == 3'd5) ? (AW+3)'(r_tap[6]) : (AW+3)'(0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            ncs_pkg::OP_PINK_TAP: begin
                if (r_rdph == 2'd0) begin
                    mul_a = AW'(r_tap[r_k]);
                    mul_b = ncs_pkg::pink_decay(r_k);
                end else begin
                    mul_a = AW'(r_w);
                    mul_b = ncs_pkg::pink_gain(r_k);
                end
            end
            ncs_pkg::OP_PINK_SUM: begin mul_a = AW'(r_w); mul_b = ncs_pkg::K_PINK_W6; end
            ncs_pkg::OP_PINK_T6:  begin mul_a = AW'(r_w); mul_b = ncs_pkg::K_PINK_T6; end
            ncs_pkg::OP_PINK_OUT: begin mul_a = AW'(r_acc); mul_b = ncs_pkg::K_PINK_OUT; end
            ncs_pkg::OP_MET_W:    begin mul_a = AW'(r_w); mul_b = ncs_pkg::K_METAL_W; end
            ncs_pkg::OP_MET_FB:   begin mul_a = AW'(r_d1); mul_b = 26'(r_fb); end
            ncs_pkg::OP_LP:       begin mul_a = AW'(x_ext - lp_ext); mul_b = coef_c; end
            ncs_pkg::OP_OUT:      begin mul_a = AW'(r_lp); mul_b = 26'({1'b0, r_level}); end
            default: ;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);

    logic in_fire, out_fire, out_load, out_from_dp;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_fire    = r_ovalid && o_out.ready;
    assign out_from_dp = (r_state == S_OUT) && (!r_ovalid || o_out.ready);
    assign out_load    = out_from_dp || (in_fire && r_level <= ncs_pkg::LEVEL_MUTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_start <= 1'b0;
        end else begin
            r_mul_start <= (r_state == S_MUL);
        end
    end

    // delay RAM writes: clearing sweep, then metallic write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_we    <= 1'b1;
            r_ram_waddr <= '0;
            r_ram_wdata <= '0;
        end else if (r_state == S_CLEAR) begin
            r_ram_we    <= 1'b1;
            r_ram_waddr <= r_clr;
            r_ram_wdata <= '0;
        end else if (r_state == S_HOLD) begin
            r_ram_we    <= 1'b1;
            r_ram_waddr <= r_widx;
            r_ram_wdata <= satsb(v_met);
        end else begin
            r_ram_we    <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (out_fire) begin
            r_ovalid <= 1'b0;
        end
        if (out_load) begin
            r_osample <= out_from_dp ? SB'(r_x) : '0;
            r_obe     <= out_from_dp ? r_be : i_in.block_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_widx   <= '0;
            r_lp     <= '0;
            r_op     <= ncs_pkg::OP_NONE;
            r_rdph   <= '0;
            for (int i = 0; i < 7; i++) r_tap[i] <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + DAW'(1);
                    if (r_clr == DAW'(DELAY_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_w    <= i_in.white_sample;
                        r_be   <= i_in.block_end;
                        r_acc  <= '0;
                        r_rdph <= '0;
                        r_k    <= '0;
                        // muted items go straight to the output register
                        if (r_level > ncs_pkg::LEVEL_MUTE) begin
                            if (r_mode == ncs_pkg::MODE_PINK) begin
                                r_op    <= ncs_pkg::OP_PINK_TAP;
                                r_state <= S_MUL;
                            end else if (r_mode == ncs_pkg::MODE_METAL) begin
                                r_op    <= ncs_pkg::OP_MET_W;
                                r_state <= S_RD;
                            end else begin
                                r_x     <= 32'(i_in.white_sample);
                                r_op    <= ncs_pkg::OP_LP;
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_RD: begin
                    // two registered reads: d[r1] then d[r2]
                    if (r_rdph == 2'd2) begin
                        r_d2    <= ram_rdata;
                        r_rdph  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        if (r_rdph == 2'd1) r_d1 <= ram_rdata;
                        r_rdph <= r_rdph + 2'd1;
                    end
                end
                S_MUL: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_done) r_state <= S_NEXT;
                end
                S_NEXT: begin
                    case (r_op)
                        ncs_pkg::OP_PINK_TAP: begin
                            r_state <= S_MUL;
                            if (r_rdph == 2'd0) begin
                                r_rdph <= 2'd1;
                                r_prod <= mul_p;
                            end else begin
                                r_tap[r_k] <= tap_new;
                                r_acc  <= r_acc + (AW+3)'(tap_new) + tap6_add;
                                r_rdph <= 2'd0;
                                if (r_k == 3'd5) r_op <= ncs_pkg::OP_PINK_SUM;
                                r_k <= r_k + 3'd1;
                            end
                        end
                        ncs_pkg::OP_PINK_SUM: begin
                            r_state <= S_MUL;
                            r_acc   <= r_acc + rnd_p(mul_p, 24);
                            r_op    <= ncs_pkg::OP_PINK_T6;
                        end
                        ncs_pkg::OP_PINK_T6: begin
                            r_state  <= S_MUL;
                            r_tap[6] <= 32'(rnd_p(mul_p, 24));
                            r_op     <= ncs_pkg::OP_PINK_OUT;
                        end
                        ncs_pkg::OP_PINK_OUT: begin
                            r_state <= S_MUL;
                            r_x     <= sat32(rnd_p(mul_p, 24));
                            r_op    <= ncs_pkg::OP_LP;
                        end
                        ncs_pkg::OP_MET_W: begin
                            r_state <= S_MUL;
                            r_acc   <= rnd_p(mul_p, 24);
                            r_op    <= ncs_pkg::OP_MET_FB;
                        end
                        ncs_pkg::OP_MET_FB: begin
                            r_state <= S_HOLD;
                            r_acc   <= r_acc + rnd_p(mul_p, 15);
                        end
                        ncs_pkg::OP_LP: begin
                            r_state <= S_MUL;
                            r_lp    <= sat32(lp_ext + rnd_p(mul_p, 24));
                            r_op    <= ncs_pkg::OP_OUT;
                        end
                        ncs_pkg::OP_OUT: begin
                            r_state <= S_OUT;
                            r_x     <= 32'(satsb(rnd_p(mul_p, 16)));
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_HOLD: begin
                    // metallic write-back value feeds the lowpass
                    r_x     <= 32'(satsb(v_met));
                    r_widx  <= (r_widx == DAW'(DELAY_DEPTH - 1)) ? '0 : r_widx + DAW'(1);
                    r_op    <= ncs_pkg::OP_LP;
                    r_state <= S_MUL;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.shaped_sample = r_osample;
    assign o_out.block_end_out = r_obe;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> r_ovalid)
        else $error("result lost");
    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_level <= ncs_pkg::LEVEL_MUTE) |=> (r_ovalid && r_osample == '0))
        else $error("muted item not zero");
`endif
endmodule

// ----- dv/noise_colour_shaper_unit_tb.sv -----
module noise_colour_shaper_unit_tb;
    import ncs_pkg::*;

    localparam int DEPTH = DelayDepthDef;
    localparam int SB    = SampleBitsDef;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 last;
    } t_noise_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ncs_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    ncs_out_if #(.SAMPLE_BITS(SB)) out_ch ();
    ncs_cfg_if                     cfg_ch ();

    noise_colour_shaper_unit #(.DELAY_DEPTH(DEPTH), .SAMPLE_BITS(SB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shaper state mirror
    logic [1:0]         sh_mode = MODE_WHITE;
    logic [15:0]        sh_tone = 16'd0;
    logic signed [15:0] sh_fb = 16'sd0;
    logic [15:0]        sh_cutoff = 16'hFFFF;
    logic [15:0]        sh_level = 16'd0;
    longint             taps [7];
    longint             lp_mem;
    longint             dline [DEPTH];
    int                 wr_pos;

    t_noise_item pending_samples [$];
    t_noise_item expected_shaped [$];
    int  errors = 0;
    bit  no_idle = 1'b0;
    int  cycles = 0;
    int  queued_cnt = 0;
    int  recv_cnt = 0;

    function automatic longint rnd(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -(longint'(1) << (bits - 1));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint kdecay(int k);
        case (k)
            0: return 16758090;
            1: return 16665144;
            2: return 16257122;
            3: return 14537458;
            4: return 9227469;
            default: return -12777528;
        endcase
    endfunction

    function automatic longint kgain(int k);
        case (k)
            0: return 931436;
            1: return 1259565;
            2: return 2581208;
            3: return 5209084;
            4: return 8941454;
            default: return -283501;
        endcase
    endfunction

    function automatic void shaper_reset();
        foreach (taps[k]) taps[k] = 0;
        lp_mem = 0;
        foreach (dline[k]) dline[k] = 0;
        wr_pos = 0;
    endfunction

    function automatic t_noise_item shape_sample(t_noise_item it);
        t_noise_item r;
        longint w, x, s, c, m;
        int len, r1, r2;
        w = it.sample;
        r.last = it.last;
        r.sample = '0;
        if (sh_level <= LEVEL_MUTE) return r;
        if (sh_mode == MODE_PINK) begin
            for (int k = 0; k < 6; k++)
                taps[k] = sat(rnd(kdecay(k) * taps[k] + kgain(k) * w, 24), 32);
            s = rnd(longint'(K_PINK_W6) * w, 24);
            for (int k = 0; k < 7; k++) s += taps[k];
            taps[6] = rnd(longint'(K_PINK_T6) * w, 24);
            x = sat(rnd(s * longint'(K_PINK_OUT), 24), 32);
        end else if (sh_mode == MODE_METAL) begin
            len = int'((longint'(sh_tone) * 250) >>> 16) + 6;
            r1 = (wr_pos + DEPTH - (len % DEPTH)) % DEPTH;
            r2 = (r1 + DEPTH - 1) % DEPTH;
            m = rnd(w * longint'(K_METAL_W), 24) + rnd(dline[r1] * longint'(sh_fb), 15);
            x = sat(rnd(m + dline[r2], 1), SB);
            dline[wr_pos] = x;
            wr_pos = (wr_pos + 1) % DEPTH;
        end else begin
            x = w;
        end
        c = rnd(longint'(sh_cutoff) * longint'(sh_cutoff), 8);
        lp_mem = sat(lp_mem + rnd(c * (x - lp_mem), 24), 32);
        r.sample = SB'(sat(rnd(lp_mem * longint'(sh_level), 16), SB));
        return r;
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(SB-1){1'b0}}};
            1: return {1'b0, {(SB-1){1'b1}}};
            2: return SB'($urandom_range(0, 64)) - SB'(32);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic void queue_item(input logic signed [SB-1:0] s, input logic l);
        pending_samples.push_back('{sample: s, last: l});
        queued_cnt++;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.white_sample <= '0;
            in_ch.block_end <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) expected_shaped.push_back(shape_sample(
                    '{sample: in_ch.white_sample, last: in_ch.block_end}));
            if (pending_samples.size() > 0 && (no_idle || $urandom_range(0, 99) >= 38)) begin
                t_noise_item it;
                it = pending_samples.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.white_sample <= it.sample;
                in_ch.block_end <= it.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                recv_cnt++;
                if (expected_shaped.size() == 0) begin
                    $error("unexpected item: shaped_sample %0d", out_ch.shaped_sample);
                    errors++;
                end else begin
                    t_noise_item e;
                    e = expected_shaped.pop_front();
                    if (out_ch.shaped_sample !== e.sample) begin
                        $error("shaped_sample expected %0d actual %0d", e.sample,
                               out_ch.shaped_sample);
                        errors++;
                    end
                    if (out_ch.block_end_out !== e.last) begin
                        $error("block_end_out expected %0d actual %0d", e.last,
                               out_ch.block_end_out);
                        errors++;
                    end
                end
            end
            out_ch.ready <= no_idle || $urandom_range(0, 99) >= 38;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL noise_colour_shaper_unit");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_MODE:     sh_mode = val[1:0];
            REG_TONE:     sh_tone = val;
            REG_FEEDBACK: sh_fb = val;
            REG_CUTOFF:   sh_cutoff = val;
            REG_LEVEL:    sh_level = val;
            default: ;
        endcase
    endtask

    // queue n random items, then wait until every queued item has come back
    task automatic run_items(input int n);
        for (int k = 0; k < n; k++)
            queue_item(rand_sample(), 1'($urandom));
        wait (recv_cnt >= queued_cnt);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        shaper_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DEPTH + 20) @(posedge i_clk);

        // muted at reset level, then boundary levels
        queue_item({1'b1, {(SB-1){1'b0}}}, 1'b1);
        queue_item({1'b0, {(SB-1){1'b1}}}, 1'b0);
        run_items(0);
        write_reg(REG_LEVEL, 16'd6);
        run_items(3);
        write_reg(REG_LEVEL, 16'd7);
        run_items(3);
        write_reg(REG_LEVEL, 16'hFFFF);
        queue_item({1'b1, {(SB-1){1'b0}}}, 1'b1);
        queue_item({1'b0, {(SB-1){1'b1}}}, 1'b0);
        run_items(2);
        write_reg(REG_MODE, MODE_PINK);
        run_items(4);
        write_reg(REG_MODE, MODE_METAL);
        write_reg(REG_FEEDBACK, 16'h7FFF);
        run_items(4);
        write_reg(3'd3 + 3'd3, 16'h1234); // out-of-range index, ignored
        write_reg(REG_MODE, 2'd3);         // unused mode acts as white
        run_items(3);

        for (int ph = 0; ph < 14; ph++) begin
            no_idle = (ph == 5);
            write_reg(REG_MODE, ph < 2 ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2)));
            write_reg(REG_TONE, ph == 3 ? 16'hFFFF : (ph == 4 ? 16'd0 : 16'($urandom)));
            write_reg(REG_FEEDBACK, ph == 6 ? 16'h8000 : (ph == 7 ? 16'h7FFF : 16'($urandom)));
            write_reg(REG_CUTOFF, ph == 8 ? 16'd0 : (ph == 9 ? 16'hFFFF : 16'($urandom)));
            write_reg(REG_LEVEL, ph == 10 ? 16'd0 : (ph == 11 ? 16'hFFFF : 16'($urandom)));
            run_items(ph == 3 ? 120 : 40);
        end
        no_idle = 1'b0;
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_shaped.size() == 0) begin
            $display("PASS noise_colour_shaper_unit");
        end else begin
            $display("FAIL noise_colour_shaper_unit");
        end
        $finish;
    end
endmodule
